// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// File: hdl/cipm_pkg.sv
// ----------------------------------------------------------------------------
// CAN identifier period monitor package
// Payload types, status codes and register indexes.
// ----------------------------------------------------------------------------
package cipm_pkg;

  localparam logic [1:0] ST_KNOWN = 2'd0;
  localparam logic [1:0] ST_NEW   = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic [2:0] REG_A_DIR = 3'd0;
  localparam logic [2:0] REG_A_ID  = 3'd1;
  localparam logic [2:0] REG_A_PER = 3'd2;
  localparam logic [2:0] REG_B_DIR = 3'd3;
  localparam logic [2:0] REG_B_ID  = 3'd4;
  localparam logic [2:0] REG_B_PER = 3'd5;
  localparam logic [2:0] REG_TOL   = 3'd6;

  typedef struct packed {
    logic        direction;
    logic [31:0] can_id;
    logic [31:0] timestamp_us;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  slot;
    logic        first_frame;
    logic [23:0] interval_us;
    logic        out_of_tolerance;
    logic [31:0] frame_count;
    logic [31:0] interval_count;
    logic [47:0] interval_sum;
    logic [63:0] interval_sq_sum;
    logic [23:0] min_interval;
    logic [23:0] max_interval;
    logic [31:0] bad_count;
  } out_item_t;

  typedef struct packed {
    logic        vld;
    logic [31:0] id;
    logic [15:0] exp_ms;
    logic        prev_vld;
    logic [31:0] prev;
    logic [31:0] frames;
    logic [31:0] ivls;
    logic [47:0] sum;
    logic [63:0] sq;
    logic [23:0] mn;
    logic [23:0] mx;
    logic [31:0] bad;
  } slot_rec_t;

endpackage

// File: hdl/cipm_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module cipm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: hdl/can_id_period_monitor.sv
// Each item runs scan, decision, read, square, add, tolerance and output states; busy is
// high from the accepting edge until it is back in idle, so no new item is taken meanwhile.
// A first frame skips the tolerance products and a dropped frame goes from decision to output.
// The slot scan reads one slot record per cycle from a single RAM port,
// then the 32x32 multiplier and the wide adders finish the update.
// Reset clears the RAM by a sweep that writes zero to every word (128 words at the defaults).
// ----------------------------------------------------------------------------
// CAN identifier period monitor
// Per-identifier frame interval statistics with period tolerance checking.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module can_id_period_monitor
  import cipm_pkg::*;
#(
  parameter int ID_SLOTS   = 64,
  parameter int DIRECTIONS = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_item_t    in_item,
  output logic        out_valid,
  output out_item_t   out_item,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  localparam int SW = (ID_SLOTS > 1) ? $clog2(ID_SLOTS) : 1;
  localparam int DW = (DIRECTIONS > 1) ? $clog2(DIRECTIONS) : 1;
  localparam int AW = SW + DW;
  localparam int DEPTH = 1 << AW;
  localparam int RW = $bits(slot_rec_t);

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_SCAN  = 9'b000000100,
    S_DEC   = 9'b000001000,
    S_READ  = 9'b000010000,
    S_MUL   = 9'b000100000,
    S_ADD   = 9'b001000000,
    S_TOL   = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  logic        a_dir_r, b_dir_r;
  logic [28:0] a_id_r, b_id_r;
  logic [15:0] a_per_r, b_per_r;
  logic [6:0]  tol_r;

  in_item_t    item_r;
  logic [SW:0] idx_r;
  logic        scan_vld_r;
  logic [SW:0] rd_idx_r;
  logic        found_r, free_r;
  logic [SW-1:0] found_slot_r, free_slot_r;
  logic [SW-1:0] slot_r;
  logic [AW:0] clr_r;
  slot_rec_t   rec_r;
  logic [1:0]  status_r;
  logic [63:0] sq_r;
  logic [31:0] d_r;
  logic [63:0] prod_r;
  logic [1:0]  tol_step_r;
  logic        bad_r;
  logic        out_valid_r;
  out_item_t   out_r;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  slot_rec_t     ram_wdata, ram_rdata;
  logic [RW-1:0] ram_rbits;

  assign ram_rdata = slot_rec_t'(ram_rbits);

  cipm_ram #(.WIDTH(RW), .DEPTH(DEPTH)) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(RW'(ram_wdata)),
    .raddr(ram_raddr),
    .rdata(ram_rbits)
  );

  logic [DW-1:0] dir_ix;
  assign dir_ix = DW'(item_r.direction);

  always_comb begin
    ram_raddr = {dir_ix, idx_r[SW-1:0]};
    if (state_r == S_DEC) begin
      ram_raddr = {dir_ix, (found_r ? found_slot_r : free_slot_r)};
    end
  end

  // Configuration port.
  logic cfg_wr;
  logic [2:0] cfg_ix;
  assign cfg_pready = 1'b1;
  assign cfg_ix = cfg_paddr[4:2];
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_dir_r <= 1'b0; a_id_r <= 29'h501; a_per_r <= 16'd100;
      b_dir_r <= 1'b1; b_id_r <= 29'h210; b_per_r <= 16'd100;
      tol_r   <= 7'd20;
    end else if (cfg_wr) begin
      unique case (cfg_ix)
        REG_A_DIR: a_dir_r <= cfg_pwdata[0];
        REG_A_ID:  a_id_r  <= cfg_pwdata[28:0];
        REG_A_PER: a_per_r <= cfg_pwdata[15:0];
        REG_B_DIR: b_dir_r <= cfg_pwdata[0];
        REG_B_ID:  b_id_r  <= cfg_pwdata[28:0];
        REG_B_PER: b_per_r <= cfg_pwdata[15:0];
        REG_TOL:   tol_r   <= cfg_pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_ix)
      REG_A_DIR: cfg_prdata = {31'd0, a_dir_r};
      REG_A_ID:  cfg_prdata = {3'd0, a_id_r};
      REG_A_PER: cfg_prdata = {16'd0, a_per_r};
      REG_B_DIR: cfg_prdata = {31'd0, b_dir_r};
      REG_B_ID:  cfg_prdata = {3'd0, b_id_r};
      REG_B_PER: cfg_prdata = {16'd0, b_per_r};
      REG_TOL:   cfg_prdata = {25'd0, tol_r};
      default:   cfg_prdata = 32'd0;
    endcase
  end

  // Shared multiplier: square of the interval, then the tolerance products.
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [25:0] exp_us;
  logic [7:0]  lo_f, hi_f;
  assign exp_us = 26'(rec_r.exp_ms) * 26'd1000;
  assign lo_f = (tol_r >= 7'd100) ? 8'd0 : 8'd100 - 8'(tol_r);
  assign hi_f = 8'd100 + 8'(tol_r);

  always_comb begin
    mul_a = d_r;
    mul_b = d_r;
    priority case (1'b1)
      tol_step_r == 2'd1: begin mul_a = 32'(exp_us); mul_b = 32'(lo_f); end
      tol_step_r == 2'd2: begin mul_a = 32'(exp_us); mul_b = 32'(hi_f); end
      tol_step_r == 2'd3: begin mul_a = d_r; mul_b = 32'd100; end
      default: ;
    endcase
  end
  assign mul_p = 64'(mul_a) * 64'(mul_b);

  logic [31:0] d_now;
  logic [23:0] ivl24;
  logic [48:0] sum_w;
  logic [64:0] sq_w;
  logic        tol_bad;
  assign d_now = item_r.timestamp_us - ram_rdata.prev;
  assign ivl24 = (d_r > 32'hFFFFFF) ? 24'hFFFFFF : d_r[23:0];
  assign sum_w = 49'(rec_r.sum) + 49'(d_r);
  assign sq_w  = 65'(rec_r.sq) + 65'(sq_r);
  assign tol_bad = (rec_r.exp_ms != 16'd0) && (mul_p < prod_r || mul_p > sq_r);

  logic [15:0] lk_per;
  always_comb begin
    priority if (a_dir_r == item_r.direction && a_id_r == item_r.can_id[28:0]) begin
      lk_per = a_per_r;
    end else if (b_dir_r == item_r.direction && b_id_r == item_r.can_id[28:0]) begin
      lk_per = b_per_r;
    end else begin
      lk_per = 16'd0;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (clr_r == (AW+1)'(DEPTH - 1)) state_nxt = S_IDLE;
      S_IDLE:  if (start && 32'(in_item.direction) < DIRECTIONS) state_nxt = S_SCAN;
      S_SCAN:  if (!scan_vld_r && idx_r == (SW+1)'(ID_SLOTS)) state_nxt = S_DEC;
      S_DEC:   state_nxt = (found_r || free_r) ? S_READ : S_OUT;
      S_READ:  state_nxt = S_MUL;
      S_MUL:   state_nxt = S_ADD;
      S_ADD:   state_nxt = S_TOL;
      S_TOL:   if (tol_step_r == 2'd3 || !rec_r.prev_vld) state_nxt = S_OUT;
      S_OUT:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    ram_we = 1'b0;
    ram_waddr = {dir_ix, slot_r};
    ram_wdata = rec_r;
    if (state_r == S_CLEAR) begin
      ram_we = 1'b1;
      ram_waddr = clr_r[AW-1:0];
      ram_wdata = '0;
    end else if (state_r == S_OUT && status_r != ST_FULL) begin
      ram_we = 1'b1;
      ram_wdata.prev = item_r.timestamp_us;
      ram_wdata.prev_vld = 1'b1;
    end
  end

  slot_rec_t rec_nxt;
  always_comb begin
    rec_nxt = rec_r;
    unique case (state_r)
      S_READ: begin
        if (status_r == ST_NEW) begin
          rec_nxt = '0;
          rec_nxt.vld = 1'b1;
          rec_nxt.id = item_r.can_id;
          rec_nxt.exp_ms = lk_per;
          rec_nxt.mn = 24'hFFFFFF;
        end else begin
          rec_nxt = ram_rdata;
        end
      end
      S_MUL: begin
        rec_nxt.frames = (&rec_r.frames) ? rec_r.frames : rec_r.frames + 32'd1;
      end
      S_ADD: begin
        if (rec_r.prev_vld) begin
          rec_nxt.ivls = (&rec_r.ivls) ? rec_r.ivls : rec_r.ivls + 32'd1;
          rec_nxt.sum = sum_w[48] ? '1 : sum_w[47:0];
          rec_nxt.sq = sq_w[64] ? '1 : sq_w[63:0];
          if (ivl24 < rec_r.mn) rec_nxt.mn = ivl24;
          if (ivl24 > rec_r.mx) rec_nxt.mx = ivl24;
        end
      end
      S_TOL: begin
        if (rec_r.prev_vld && tol_step_r == 2'd3 && tol_bad) begin
          rec_nxt.bad = (&rec_r.bad) ? rec_r.bad : rec_r.bad + 32'd1;
        end
      end
      default: ;
    endcase
  end

  out_item_t out_nxt;
  always_comb begin
    out_nxt = '0;
    out_nxt.status = status_r;
    if (status_r != ST_FULL) begin
      out_nxt.slot = 6'(slot_r);
      out_nxt.first_frame = !rec_r.prev_vld;
      out_nxt.interval_us = rec_r.prev_vld ? ivl24 : 24'd0;
      out_nxt.out_of_tolerance = bad_r;
      out_nxt.frame_count = rec_r.frames;
      out_nxt.interval_count = rec_r.ivls;
      out_nxt.interval_sum = rec_r.sum;
      out_nxt.interval_sq_sum = rec_r.sq;
      out_nxt.min_interval = rec_r.mn;
      out_nxt.max_interval = rec_r.mx;
      out_nxt.bad_count = rec_r.bad;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r <= '0;
      out_valid_r <= 1'b0;
      scan_vld_r <= 1'b0;
      tol_step_r <= 2'd0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= (state_r == S_OUT);
      rec_r <= rec_nxt;
      unique case (state_r)
        S_CLEAR: clr_r <= clr_r + (AW+1)'(1);
        S_IDLE: begin
          item_r <= in_item;
          idx_r <= '0;
          scan_vld_r <= 1'b0;
          found_r <= 1'b0;
          free_r <= 1'b0;
          tol_step_r <= 2'd0;
          bad_r <= 1'b0;
        end
        S_SCAN: begin
          scan_vld_r <= (idx_r < (SW+1)'(ID_SLOTS));
          rd_idx_r <= idx_r;
          if (idx_r < (SW+1)'(ID_SLOTS)) idx_r <= idx_r + (SW+1)'(1);
          if (scan_vld_r) begin
            if (ram_rdata.vld) begin
              if (!found_r && ram_rdata.id == item_r.can_id) begin
                found_r <= 1'b1;
                found_slot_r <= rd_idx_r[SW-1:0];
              end
            end else if (!free_r) begin
              free_r <= 1'b1;
              free_slot_r <= rd_idx_r[SW-1:0];
            end
          end
        end
        S_DEC: begin
          slot_r <= found_r ? found_slot_r : free_slot_r;
          status_r <= found_r ? ST_KNOWN : (free_r ? ST_NEW : ST_FULL);
        end
        S_READ: begin
          d_r <= (status_r == ST_NEW) ? 32'd0 : d_now;
        end
        S_MUL: begin
          sq_r <= mul_p;
        end
        S_ADD: begin
          if (rec_r.prev_vld) begin
            tol_step_r <= 2'd1;
          end
        end
        S_TOL: begin
          if (rec_r.prev_vld) begin
            tol_step_r <= tol_step_r + 2'd1;
            if (tol_step_r == 2'd1) prod_r <= mul_p;
            if (tol_step_r == 2'd2) sq_r <= mul_p;
            if (tol_step_r == 2'd3 && tol_bad) bad_r <= 1'b1;
          end
        end
        S_OUT: begin
          out_r <= out_nxt;
        end
        default: ;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  `ASSERT_NEXT(a_out_after, clk, rst_n, state_r == S_OUT, out_valid, "missing result strobe")
  `ASSERT_IMPL(a_out_idle, clk, rst_n, out_valid, state_r == S_IDLE, "result outside idle")
  `ASSERT_IMPL(a_full_zero, clk, rst_n, out_valid && out_item.status == ST_FULL,
    out_item.frame_count == 32'd0, "dropped item carries data")
endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CAN identifier period monitor testbench
// Drives frames through the command port, predicts each result with an own
// slot table model and compares every field; registers are set over APB.
// ----------------------------------------------------------------------------
module testbench;
  import cipm_pkg::*;

  localparam int NSLOT = 64;
  localparam int NDIR  = 2;
  localparam longint LIMIT = 4000000;

  class period_board;
    bit [0:0]  a_dir, b_dir;
    bit [28:0] a_id, b_id;
    bit [15:0] a_per, b_per;
    bit [6:0]  tol;
    bit        vld [NDIR][NSLOT];
    bit [31:0] sid [NDIR][NSLOT];
    bit [15:0] sexp [NDIR][NSLOT];
    bit        hasp [NDIR][NSLOT];
    bit [31:0] prev [NDIR][NSLOT];
    bit [31:0] frm [NDIR][NSLOT];
    bit [31:0] ivc [NDIR][NSLOT];
    bit [47:0] sm [NDIR][NSLOT];
    bit [63:0] sq [NDIR][NSLOT];
    bit [23:0] mn [NDIR][NSLOT];
    bit [23:0] mx [NDIR][NSLOT];
    bit [31:0] bd [NDIR][NSLOT];
    out_item_t pending[$];
    int errors;
    int checked;

    function new();
      a_dir = 0; a_id = 29'h501; a_per = 100;
      b_dir = 1; b_id = 29'h210; b_per = 100;
      tol = 20;
      foreach (vld[d, s]) begin
        vld[d][s] = 0;
        hasp[d][s] = 0;
      end
      errors = 0;
      checked = 0;
    endfunction

    function void set_reg(int idx, bit [31:0] v);
      case (idx)
        REG_A_DIR: a_dir = v[0];
        REG_A_ID:  a_id = v[28:0];
        REG_A_PER: a_per = v[15:0];
        REG_B_DIR: b_dir = v[0];
        REG_B_ID:  b_id = v[28:0];
        REG_B_PER: b_per = v[15:0];
        REG_TOL:   tol = v[6:0];
        default: ;
      endcase
    endfunction

    function bit [31:0] sat_inc(bit [31:0] v);
      return (v == 32'hFFFF_FFFF) ? v : v + 1;
    endfunction

    function void note_frame(in_item_t it);
      out_item_t r;
      int found, free, s, d;
      bit [31:0] dt;
      bit [63:0] dsq, nsq;
      bit [48:0] nsum;
      bit [23:0] i24;
      longint unsigned exp_us, scaled, lo_f, hi_f;
      r = '0;
      d = it.direction;
      found = -1;
      free = -1;
      for (int i = 0; i < NSLOT; i++) begin
        if (vld[d][i]) begin
          if (found < 0 && sid[d][i] == it.can_id) found = i;
        end else if (free < 0) begin
          free = i;
        end
      end
      if (found < 0 && free < 0) begin
        r.status = ST_FULL;
        pending.push_back(r);
        return;
      end
      r.status = ST_KNOWN;
      if (found < 0) begin
        s = free;
        vld[d][s] = 1;
        sid[d][s] = it.can_id;
        if (a_dir == d && a_id == it.can_id[28:0]) sexp[d][s] = a_per;
        else if (b_dir == d && b_id == it.can_id[28:0]) sexp[d][s] = b_per;
        else sexp[d][s] = 0;
        hasp[d][s] = 0;
        frm[d][s] = 0; ivc[d][s] = 0; sm[d][s] = 0; sq[d][s] = 0;
        mn[d][s] = 24'hFF_FFFF; mx[d][s] = 0; bd[d][s] = 0;
        r.status = ST_NEW;
      end else begin
        s = found;
      end
      if (hasp[d][s]) begin
        dt = it.timestamp_us - prev[d][s];
        dsq = 64'(dt) * 64'(dt);
        i24 = (dt > 32'hFF_FFFF) ? 24'hFF_FFFF : dt[23:0];
        r.interval_us = i24;
        ivc[d][s] = sat_inc(ivc[d][s]);
        nsum = 49'(sm[d][s]) + 49'(dt);
        sm[d][s] = nsum[48] ? 48'hFFFF_FFFF_FFFF : nsum[47:0];
        nsq = sq[d][s] + dsq;
        sq[d][s] = (nsq < sq[d][s]) ? 64'hFFFF_FFFF_FFFF_FFFF : nsq;
        if (i24 < mn[d][s]) mn[d][s] = i24;
        if (i24 > mx[d][s]) mx[d][s] = i24;
        if (sexp[d][s] != 0) begin
          exp_us = longint'(sexp[d][s]) * 1000;
          scaled = longint'(dt) * 100;
          lo_f = (tol >= 100) ? 0 : 100 - tol;
          hi_f = 100 + tol;
          if (scaled < exp_us * lo_f || scaled > exp_us * hi_f) begin
            r.out_of_tolerance = 1;
            bd[d][s] = sat_inc(bd[d][s]);
          end
        end
      end else begin
        r.first_frame = 1;
      end
      prev[d][s] = it.timestamp_us;
      hasp[d][s] = 1;
      frm[d][s] = sat_inc(frm[d][s]);
      r.slot = s[5:0];
      r.frame_count = frm[d][s];
      r.interval_count = ivc[d][s];
      r.interval_sum = sm[d][s];
      r.interval_sq_sum = sq[d][s];
      r.min_interval = mn[d][s];
      r.max_interval = mx[d][s];
      r.bad_count = bd[d][s];
      pending.push_back(r);
    endfunction

    function void check_result(out_item_t got);
      out_item_t e;
      if (pending.size() == 0) begin
        $error("result with no frame waiting");
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (got.status !== e.status) begin
        $error("status exp %0d got %0d", e.status, got.status); errors++;
      end
      if (got.slot !== e.slot) begin
        $error("slot exp %0d got %0d", e.slot, got.slot); errors++;
      end
      if (got.first_frame !== e.first_frame) begin
        $error("first_frame exp %0d got %0d", e.first_frame, got.first_frame); errors++;
      end
      if (got.interval_us !== e.interval_us) begin
        $error("interval_us exp %0d got %0d", e.interval_us, got.interval_us); errors++;
      end
      if (got.out_of_tolerance !== e.out_of_tolerance) begin
        $error("out_of_tolerance exp %0d got %0d", e.out_of_tolerance,
               got.out_of_tolerance); errors++;
      end
      if (got.frame_count !== e.frame_count) begin
        $error("frame_count exp %0d got %0d", e.frame_count, got.frame_count); errors++;
      end
      if (got.interval_count !== e.interval_count) begin
        $error("interval_count exp %0d got %0d", e.interval_count,
               got.interval_count); errors++;
      end
      if (got.interval_sum !== e.interval_sum) begin
        $error("interval_sum exp %0d got %0d", e.interval_sum, got.interval_sum); errors++;
      end
      if (got.interval_sq_sum !== e.interval_sq_sum) begin
        $error("interval_sq_sum exp %0d got %0d", e.interval_sq_sum,
               got.interval_sq_sum); errors++;
      end
      if (got.min_interval !== e.min_interval) begin
        $error("min_interval exp %0d got %0d", e.min_interval, got.min_interval); errors++;
      end
      if (got.max_interval !== e.max_interval) begin
        $error("max_interval exp %0d got %0d", e.max_interval, got.max_interval); errors++;
      end
      if (got.bad_count !== e.bad_count) begin
        $error("bad_count exp %0d got %0d", e.bad_count, got.bad_count); errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_item_t    in_item;
  logic        out_valid;
  out_item_t   out_item;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [4:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  period_board board;
  longint cycles;
  int idle_pct;
  int frames_sent;
  bit [31:0] clock_us [NDIR];
  bit [31:0] id_pool [16];

  can_id_period_monitor i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .cfg_psel(cfg_psel),
    .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite), .cfg_paddr(cfg_paddr),
    .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata), .cfg_pready(cfg_pready)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
    if (rst_n && out_valid) board.check_result(out_item);
  end

  task automatic write_reg(int idx, bit [31:0] v);
    @(negedge clk);
    cfg_psel <= 1; cfg_penable <= 0; cfg_pwrite <= 1;
    cfg_paddr <= 5'(4 * idx); cfg_pwdata <= v;
    @(negedge clk);
    cfg_penable <= 1;
    do @(posedge clk); while (!cfg_pready);
    board.set_reg(idx, v);
    @(negedge clk);
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
  endtask

  task automatic drain();
    while (board.pending.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic send_frame(bit dir, bit [31:0] id, bit [31:0] ts);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) @(negedge clk);
    start <= 1;
    in_item <= '{direction: dir, can_id: id, timestamp_us: ts};
    do @(posedge clk); while (busy);
    board.note_frame('{direction: dir, can_id: id, timestamp_us: ts});
    frames_sent++;
    @(negedge clk);
    start <= 0;
  endtask

  // Frames with a period near the expected one, with occasional jumps.
  task automatic send_periodic(bit dir, bit [31:0] id, int per_ms);
    bit [31:0] step;
    int k;
    k = $urandom_range(99);
    if (k < 70) step = per_ms * 1000 * (70 + $urandom_range(60)) / 100;
    else if (k < 85) step = $urandom_range(2000);
    else step = $urandom;
    clock_us[dir] += step;
    send_frame(dir, id, clock_us[dir]);
  endtask

  task automatic random_config();
    write_reg(REG_A_DIR, $urandom);
    write_reg(REG_A_ID, id_pool[$urandom_range(15)] | ($urandom & 32'hE000_0000));
    write_reg(REG_A_PER, $urandom_range(3) == 0 ? $urandom : $urandom_range(200));
    write_reg(REG_B_DIR, $urandom);
    write_reg(REG_B_ID, id_pool[$urandom_range(15)]);
    write_reg(REG_B_PER, $urandom_range(3) == 0 ? 0 : $urandom_range(300));
    write_reg(REG_TOL, $urandom_range(3) == 0 ? 100 : $urandom_range(100));
  endtask

  initial begin
    bit [31:0] id;
    bit dir;
    int n;
    board = new();
    cycles = 0;
    frames_sent = 0;
    idle_pct = 0;
    rst_n = 0; start = 0; in_item = '0;
    cfg_psel = 0; cfg_penable = 0; cfg_pwrite = 0; cfg_paddr = '0; cfg_pwdata = '0;
    clock_us[0] = 0; clock_us[1] = 0;
    for (int i = 0; i < 16; i++) id_pool[i] = $urandom & 32'h1FFF_FFFF;
    id_pool[0] = 32'h501; id_pool[1] = 32'h210;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // Directed: reset periods, extremes, wrap, flag bits, full table.
    send_frame(0, 32'h501, 32'd0);
    send_frame(0, 32'h501, 32'd100000);
    send_frame(0, 32'h501, 32'd180000);
    send_frame(0, 32'h501, 32'd300001);
    send_frame(0, 32'h8000_0501, 32'hFFFF_FFF0);
    send_frame(0, 32'h8000_0501, 32'h0000_0010);
    send_frame(1, 32'h210, 32'hFFFF_FFFF);
    send_frame(1, 32'h210, 32'hFFFF_FFFE);
    send_frame(1, 32'hFFFF_FFFF, 32'd0);
    send_frame(1, 32'hFFFF_FFFF, 32'd0);
    send_frame(1, 32'h0, 32'd5);
    drain();
    write_reg(REG_TOL, 0);
    write_reg(REG_A_PER, 16'hFFFF);
    write_reg(REG_A_ID, 32'h1FFF_FFFF);
    write_reg(REG_A_DIR, 1);
    write_reg(REG_B_PER, 0);
    write_reg(REG_B_DIR, 0);
    write_reg(REG_B_ID, 0);
    send_frame(1, 32'hFFFF_FFFF, 32'd65535000);
    send_frame(1, 32'hFFFF_FFFF, 32'd131070000);
    // Table full on direction 0 only.
    for (int i = 0; i < NSLOT + 2; i++) send_frame(0, 32'h1000 + i, i);
    drain();
    write_reg(REG_TOL, 100);

    // Random phases; table 0 stays full, so new ids there are dropped.
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 29 : (ph == 1) ? 81 : 0;
      n = (ph == 1) ? 350 : 700;
      for (int j = 0; j < n; j++) begin
        if (j % 200 == 199) begin
          drain();
          random_config();
        end
        dir = $urandom;
        if ($urandom_range(9) == 0) begin
          id = $urandom;
          send_frame(dir, id, $urandom);
        end else begin
          id = dir ? id_pool[$urandom_range(15)] : 32'h1000 + $urandom_range(63);
          send_periodic(dir, id, 1 + $urandom_range(150));
        end
      end
      drain();
    end

    drain();
    $display("Sent %0d frames, checked %0d results over several register settings.",
             frames_sent, board.checked);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end
endmodule
